>>> rtl/stgb_pkg.sv
`default_nettype none

package stgb_pkg;

  // pixel layout
  localparam int CH     = 3;
  localparam int CHAN_W = 8;
  localparam int PIX_W  = CH * CHAN_W;

  localparam logic [CHAN_W-1:0] COV_FULL = 8'hFF;

  // squared byte, weighted sum of squares
  localparam int SQ_W   = 2 * CHAN_W;
  localparam int PROD_W = SQ_W + CHAN_W;

  // floor(x / 255) as (x * ceil(2^32 / 255)) >> 32, exact for x below 2^24
  localparam int                 RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP   = 25'd16843010;
  localparam int                 MUL_W   = PROD_W + RECIP_W;
  localparam int                 Q_LSB   = 32;

  // square root chain: two radicand bits and one root bit per cell
  localparam int RAD_W  = SQ_W;
  localparam int ROOT_W = CHAN_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEPS  = RAD_W / 2;

  // data handed from one root cell to the next
  typedef struct packed {
    logic                          valid;
    logic [CH-1:0][RAD_W-1:0]      rad;
    logic [CH-1:0][REM_W-1:0]      rem;
    logic [CH-1:0][ROOT_W-1:0]     root;
  } cell_t;

endpackage

`default_nettype wire

>>> rtl/stgb_front.sv
`default_nettype none

module stgb_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [stgb_pkg::PIX_W-1:0] coverage_pixel,
  input  wire logic [stgb_pkg::PIX_W-1:0] dest_pixel,
  input  wire logic [stgb_pkg::PIX_W-1:0] text_color,
  output stgb_pkg::cell_t               head
);

  logic v1, v2, v3, v4;

  logic [stgb_pkg::CH-1:0][stgb_pkg::SQ_W-1:0]   sq_d;
  logic [stgb_pkg::CH-1:0][stgb_pkg::SQ_W-1:0]   sq_c;
  logic [stgb_pkg::CH-1:0][stgb_pkg::CHAN_W-1:0] cov1;
  logic [stgb_pkg::CH-1:0][stgb_pkg::PROD_W-1:0] p_d;
  logic [stgb_pkg::CH-1:0][stgb_pkg::PROD_W-1:0] p_c;
  logic [stgb_pkg::CH-1:0][stgb_pkg::PROD_W-1:0] sum;
  logic [stgb_pkg::CH-1:0][stgb_pkg::MUL_W-1:0]  prod;
  logic [stgb_pkg::CH-1:0][stgb_pkg::RAD_W-1:0]  quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // reciprocal multiply for the divide by 255
  always_comb begin
    for (int i = 0; i < stgb_pkg::CH; i++) begin
      prod[i] = stgb_pkg::MUL_W'(sum[i]) * stgb_pkg::MUL_W'(stgb_pkg::RECIP);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < stgb_pkg::CH; i++) begin
      // squares of the byte values
      sq_d[i] <= stgb_pkg::SQ_W'(dest_pixel[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W])
               * stgb_pkg::SQ_W'(dest_pixel[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W]);
      sq_c[i] <= stgb_pkg::SQ_W'(text_color[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W])
               * stgb_pkg::SQ_W'(text_color[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W]);
      cov1[i] <= coverage_pixel[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W];
      // coverage weights
      p_d[i]  <= stgb_pkg::PROD_W'(sq_d[i])
               * stgb_pkg::PROD_W'(stgb_pkg::COV_FULL - cov1[i]);
      p_c[i]  <= stgb_pkg::PROD_W'(sq_c[i]) * stgb_pkg::PROD_W'(cov1[i]);
      // at most 255 * 65025, fits 24 bits
      sum[i]  <= p_d[i] + p_c[i];
      // quotient is at most 65025, top product bits are zero
      quot[i] <= prod[i][stgb_pkg::Q_LSB +: stgb_pkg::RAD_W];
    end
  end

  always_comb begin
    head.valid = v4;
    head.rad   = quot;
    head.rem   = '0;
    head.root  = '0;
  end

endmodule

`default_nettype wire

>>> rtl/stgb_sqrt_cell.sv
`default_nettype none

module stgb_sqrt_cell (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire stgb_pkg::cell_t prev,
  output stgb_pkg::cell_t next
);

  stgb_pkg::cell_t cell_next;

  logic [stgb_pkg::CH-1:0][stgb_pkg::REM_W+1:0] rem_sh;
  logic [stgb_pkg::CH-1:0][stgb_pkg::REM_W+1:0] trial;

  always_comb begin
    cell_next.valid = prev.valid;
    for (int i = 0; i < stgb_pkg::CH; i++) begin
      // bring down the next two radicand bits
      rem_sh[i] = {prev.rem[i], prev.rad[i][stgb_pkg::RAD_W-1 -: 2]};
      trial[i]  = {2'b00, prev.root[i], 2'b01};
      cell_next.rad[i] = {prev.rad[i][stgb_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh[i] >= trial[i]) begin
        cell_next.rem[i]  = stgb_pkg::REM_W'(rem_sh[i] - trial[i]);
        cell_next.root[i] = {prev.root[i][stgb_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        cell_next.rem[i]  = rem_sh[i][stgb_pkg::REM_W-1:0];
        cell_next.root[i] = {prev.root[i][stgb_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else begin
      next.valid <= cell_next.valid;
    end
    next.rad  <= cell_next.rad;
    next.rem  <= cell_next.rem;
    next.root <= cell_next.root;
  end

endmodule

`default_nettype wire

>>> rtl/subpixel_text_gamma_blend_top.sv
// the done strobe comes with blended_pixel for each item accepted while start is high
// throughput: one item per cycle; busy is held low, so start may be high every cycle
// stages: squares, coverage weights, sum, divide by 255, 8 root cells, round
// reset (rst, synchronous, active high) clears text_color and every stage valid
// done is a one-cycle strobe, the receiver cannot stall it
`default_nettype none

module subpixel_text_gamma_blend_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // item channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [stgb_pkg::PIX_W-1:0]   coverage_pixel,
  input  wire logic [stgb_pkg::PIX_W-1:0]   dest_pixel,
  // result channel
  output logic                              done,
  output logic [stgb_pkg::PIX_W-1:0]        blended_pixel,
  // text color register
  input  wire logic                         cfg_we,
  input  wire logic [stgb_pkg::PIX_W-1:0]   cfg_wdata
);

  logic [stgb_pkg::PIX_W-1:0] text_color;

  // chain[0] is the front end output, chain[STEPS] the last root cell
  stgb_pkg::cell_t chain [stgb_pkg::STEPS+1];

  logic [stgb_pkg::PIX_W-1:0] rounded;

  // fully pipelined, nothing ever holds the input off
  assign busy = 1'b0;

  // text color, to be written only between items by the user; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= '0;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  // squares, weighted sum and exact divide by 255 per channel
  stgb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (start && !busy),
    .coverage_pixel (coverage_pixel),
    .dest_pixel     (dest_pixel),
    .text_color     (text_color),
    .head           (chain[0])
  );

  // restoring square root, one root bit per cell, all three channels side by side
  for (genvar k = 0; k < stgb_pkg::STEPS; k++) begin : g_root
    stgb_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (chain[k]),
      .next (chain[k+1])
    );
  end

  // round to nearest: remainder L - r*r above r means the root is nearer r + 1
  // (never overflows, since L is at most 255 squared)
  always_comb begin
    for (int i = 0; i < stgb_pkg::CH; i++) begin
      if (chain[stgb_pkg::STEPS].rem[i] >
          stgb_pkg::REM_W'(chain[stgb_pkg::STEPS].root[i])) begin
        rounded[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W] =
          chain[stgb_pkg::STEPS].root[i] + 1'b1;
      end else begin
        rounded[i*stgb_pkg::CHAN_W +: stgb_pkg::CHAN_W] =
          chain[stgb_pkg::STEPS].root[i];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[stgb_pkg::STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    blended_pixel <= rounded;
  end

`ifndef SYNTHESIS
  // every strobe comes from an accepted item
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 13))
    else $error("done without a matching item");

  // full coverage on every channel gives the text color back
  a_full_cov: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start, 13) && $past(coverage_pixel, 13) == 24'hFFFFFF)
      |-> blended_pixel == $past(text_color, 13))
    else $error("full coverage did not give the text color");

  // zero coverage keeps the destination pixel
  a_zero_cov: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start, 13) && $past(coverage_pixel, 13) == 24'h000000)
      |-> blended_pixel == $past(dest_pixel, 13))
    else $error("zero coverage changed the destination");
`endif

endmodule

`default_nettype wire
